@@ rtl/rgb_to_hsl_converter_assert.svh @@
// ----------------------------------------------------------------------------
// RGB to HSL converter assertion macros
// Concurrent assertion wrappers that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSL_CONVERTER_ASSERT_SVH
`define RGB_TO_HSL_CONVERTER_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, checked while out of reset.
`define R2H_ASSERT_IMP(name, clk_i, rstn_i, ante, cons) \
	name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error("rgb_to_hsl_converter: assertion failed");

// Next-cycle implication, checked while out of reset.
`define R2H_ASSERT_NXT(name, clk_i, rstn_i, ante, cons) \
	name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error("rgb_to_hsl_converter: assertion failed");

`else

`define R2H_ASSERT_IMP(name, clk_i, rstn_i, ante, cons)
`define R2H_ASSERT_NXT(name, clk_i, rstn_i, ante, cons)

`endif

`endif

@@ rtl/r2h_pkg.sv @@
// ----------------------------------------------------------------------------
// RGB to HSL converter package
// Default sizes, saturation scale, sector codes and the divider depth.
// ----------------------------------------------------------------------------
package r2h_pkg;

	localparam int CHANNEL_BITS_DEF  = 8;
	localparam int HUE_FRAC_BITS_DEF = 10;
	localparam int SAT_FRAC_BITS     = 12;

	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

	// Both divisions run side by side, so the deeper one sets the step count.
	function automatic int r2h_steps(input int hue_frac);
		int sat_steps;
		int hue_steps;
		sat_steps = SAT_FRAC_BITS + 1;
		hue_steps = hue_frac + 1;
		return (sat_steps > hue_steps) ? sat_steps : hue_steps;
	endfunction

endpackage

@@ rtl/r2h_div.sv @@
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Computes floor(num*2^FRAC/den), num <= den, one quotient bit per non-pad stage.
// ----------------------------------------------------------------------------
module r2h_div #(
	parameter int W     = 8,
	parameter int FRAC  = 12,
	parameter int STEPS = 13
) (
	input  logic             clk,
	input  logic [STEPS-1:0] en,
	input  logic [W-1:0]     num,
	input  logic [W-1:0]     den,
	output logic [FRAC:0]    quo
);

	localparam int PAD = STEPS - FRAC - 1;

	logic [W-1:0] rem_s2 [STEPS];
	logic [W-1:0] den_s2 [STEPS];
	logic [FRAC:0] quo_s2 [STEPS];

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic [W-1:0]  rem_in;
		logic [W-1:0]  den_in;
		logic [FRAC:0] quo_in;
		logic [W-1:0]  rem_n;
		logic [FRAC:0] quo_n;

		if (k == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s2[k-1];
			assign den_in = den_s2[k-1];
			assign quo_in = quo_s2[k-1];
		end

		if (k < PAD) begin : g_pad
			assign rem_n = rem_in;
			assign quo_n = quo_in;
		end else begin : g_bit
			logic [W:0] trial;
			logic       ge;

			// The integer step compares the remainder as is, later steps shift it first.
			if (k == PAD) begin : g_int
				assign trial = {1'b0, rem_in};
			end else begin : g_frac
				assign trial = {rem_in, 1'b0};
			end
			assign ge    = (trial >= {1'b0, den_in});
			assign rem_n = ge ? W'(trial - {1'b0, den_in}) : trial[W-1:0];
			assign quo_n = {quo_in[FRAC-1:0], ge};
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_s2[k] <= rem_n;
				den_s2[k] <= den_in;
				quo_s2[k] <= quo_n;
			end
		end
	end

	assign quo = quo_s2[STEPS-1];

endmodule

@@ rtl/rgb_to_hsl_converter.sv @@
// ----------------------------------------------------------------------------
// RGB to HSL converter
// Converts one RGB pixel per cycle, while the receiver does not stall, into
// fixed-point hue, saturation and lightness through a fully pipelined datapath.
// ----------------------------------------------------------------------------
// The slave side takes one pixel per item on s_tdata (red, green, blue from
// the lowest bit up). The master side returns one result per item on
// m_tdata (hue, saturation, lightness_sum from the lowest bit up).
// The datapath has one stage for the channel maximum, minimum and
// differences, one stage per step of the two restoring dividers, which run
// side by side so that the deeper division sets the step count, and one
// output stage for the sector offset and clamping.
// Throughput is one item per cycle while the receiver accepts; the divider
// stages set the depth, not the rate.
// Reset clears all valid bits; no item is in flight afterwards.
// When the receiver stalls, each stage holds only while the one after it is
// full, so bubbles close up and s_tready drops only when the whole pipeline
// is occupied. Items are never dropped or repeated.
// ----------------------------------------------------------------------------
`include "rgb_to_hsl_converter_assert.svh"

module rgb_to_hsl_converter import r2h_pkg::*; #(
	parameter int CHANNEL_BITS  = CHANNEL_BITS_DEF,
	parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF,
	localparam int IN_W  = ((3 * CHANNEL_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((HUE_FRAC_BITS + 3 + SAT_FRAC_BITS + CHANNEL_BITS + 1 + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,  // red, green, blue
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata   // hue, saturation, lightness_sum
);

	localparam int CB    = CHANNEL_BITS;
	localparam int HB    = HUE_FRAC_BITS + 3;
	localparam int HS    = HUE_FRAC_BITS + 4;
	localparam int STEPS = r2h_steps(HUE_FRAC_BITS);
	localparam int FULL  = (1 << CB) - 1;
	localparam int UNIT  = 1 << HUE_FRAC_BITS;

	typedef struct packed {
		logic        zero;
		logic        neg;
		sector_t     sector;
		logic [CB:0] sum;
	} side_t;

	logic [CB-1:0] red;
	logic [CB-1:0] green;
	logic [CB-1:0] blue;
	logic [CB-1:0] mx;
	logic [CB-1:0] mn;
	logic [CB:0]   sum_n;
	logic [CB-1:0] denom_n;
	logic [CB:0]   diff_n;
	logic [CB-1:0] anum_n;
	side_t         side_n;

	logic          en_s1;
	logic          v_s1;
	logic [CB-1:0] d_s1;
	logic [CB-1:0] den_s1;
	logic [CB-1:0] anum_s1;
	side_t         side_s1;

	logic [STEPS-1:0] en_s2;
	logic             v_s2 [STEPS];
	side_t            side_s2 [STEPS];

	logic [SAT_FRAC_BITS:0] quo_sat;
	logic [HUE_FRAC_BITS:0] quo_hue;

	logic                     en_s3;
	logic                     v_s3;
	logic [HB-1:0]            hue_s3;
	logic [SAT_FRAC_BITS-1:0] sat_s3;
	logic [CB:0]              lit_s3;

	side_t                    side_last;
	logic [HS-1:0]            off;
	logic [HS-1:0]            hue_w;
	logic [HS-1:0]            hue_adj;
	logic [HB-1:0]            hue_n;
	logic [SAT_FRAC_BITS-1:0] sat_n;

	// Stage 1: extremes, lightness, denominators and hue numerator.
	assign red   = s_tdata[CB-1:0];
	assign green = s_tdata[2*CB-1:CB];
	assign blue  = s_tdata[3*CB-1:2*CB];

	always_comb begin
		mx = red;
		if (green > mx) begin
			mx = green;
		end
		if (blue > mx) begin
			mx = blue;
		end
		mn = red;
		if (green < mn) begin
			mn = green;
		end
		if (blue < mn) begin
			mn = blue;
		end
		sum_n = {1'b0, mx} + {1'b0, mn};
		if (sum_n <= (CB+1)'(FULL)) begin
			denom_n = sum_n[CB-1:0];
		end else begin
			denom_n = CB'((CB+1)'(2 * FULL) - sum_n);
		end
		side_n.sum  = sum_n;
		side_n.zero = (mx == mn);
		priority if (mx == red) begin
			side_n.sector = SEC_RED;
			diff_n        = {1'b0, green} - {1'b0, blue};
		end else if (mx == green) begin
			side_n.sector = SEC_GREEN;
			diff_n        = {1'b0, blue} - {1'b0, red};
		end else begin
			side_n.sector = SEC_BLUE;
			diff_n        = {1'b0, red} - {1'b0, green};
		end
		side_n.neg = diff_n[CB];
		anum_n     = diff_n[CB] ? CB'(-diff_n) : diff_n[CB-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			d_s1    <= mx - mn;
			den_s1  <= denom_n;
			anum_s1 <= anum_n;
			side_s1 <= side_n;
		end
	end

	// Stage 2: both quotients, one bit per step after any padding steps.
	r2h_div #(
		.W     (CB),
		.FRAC  (SAT_FRAC_BITS),
		.STEPS (STEPS)
	) u_sat_div (
		.clk (clk),
		.en  (en_s2),
		.num (d_s1),
		.den (den_s1),
		.quo (quo_sat)
	);

	r2h_div #(
		.W     (CB),
		.FRAC  (HUE_FRAC_BITS),
		.STEPS (STEPS)
	) u_hue_div (
		.clk (clk),
		.en  (en_s2),
		.num (anum_s1),
		.den (d_s1),
		.quo (quo_hue)
	);

	for (genvar k = 0; k < STEPS; k++) begin : g_side
		logic  v_in;
		side_t side_in;

		if (k == 0) begin : g_first
			assign v_in    = v_s1;
			assign side_in = side_s1;
		end else begin : g_next
			assign v_in    = v_s2[k-1];
			assign side_in = side_s2[k-1];
		end

		if (k == STEPS - 1) begin : g_last
			assign en_s2[k] = !v_s2[k] || en_s3;
		end else begin : g_mid
			assign en_s2[k] = !v_s2[k] || en_s2[k+1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s2[k] <= 1'b0;
			end else if (en_s2[k]) begin
				v_s2[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en_s2[k]) begin
				side_s2[k] <= side_in;
			end
		end
	end

	assign en_s1    = !v_s1 || en_s2[0];
	assign s_tready = en_s1;

	// Stage 3: sector offset, wrap and clamping.
	assign side_last = side_s2[STEPS-1];

	always_comb begin
		unique case (side_last.sector)
			SEC_RED:   off = '0;
			SEC_GREEN: off = HS'(2 * UNIT);
			SEC_BLUE:  off = HS'(4 * UNIT);
			default:   off = '0;
		endcase
		if (side_last.neg) begin
			hue_w = off - HS'(quo_hue);
		end else begin
			hue_w = off + HS'(quo_hue);
		end
		if (hue_w[HS-1]) begin
			hue_adj = hue_w + HS'(6 * UNIT);
		end else begin
			hue_adj = hue_w;
		end
		if (side_last.zero) begin
			hue_n = '0;
			sat_n = '0;
		end else begin
			hue_n = hue_adj[HB-1:0];
			sat_n = quo_sat[SAT_FRAC_BITS] ? '1 : quo_sat[SAT_FRAC_BITS-1:0];
		end
	end

	assign en_s3 = !v_s3 || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en_s3) begin
			v_s3 <= v_s2[STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			hue_s3 <= hue_n;
			sat_s3 <= sat_n;
			lit_s3 <= side_last.sum;
		end
	end

	assign m_tvalid = v_s3;
	assign m_tdata  = OUT_W'({lit_s3, sat_s3, hue_s3});

	`R2H_ASSERT_IMP(a_grey_hue_zero, clk, arst_n, v_s3 && (sat_s3 == '0), hue_s3 == '0)
	`R2H_ASSERT_IMP(a_hue_in_range, clk, arst_n, v_s3, hue_s3 < HB'(6 * UNIT))
	`R2H_ASSERT_NXT(a_accept_lands, clk, arst_n, s_tvalid && s_tready, v_s1)
	`R2H_ASSERT_IMP(a_stall_only_full, clk, arst_n, !s_tready, v_s1 && v_s2[0])

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// RGB to HSL converter testbench
// Sends a table of directed pixels and then random pixels with random gaps
// on both stream sides, including one long output stall. Each result is
// checked field by field against its table row or a built-in HSL predictor.
// ----------------------------------------------------------------------------
module tb import r2h_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int IN_W        = 24;
	localparam int OUT_W       = 40;
	localparam int FULL        = (1 << CHANNEL_BITS_DEF) - 1;
	localparam int HUE_UNIT    = 1 << HUE_FRAC_BITS_DEF;
	localparam int SAT_ONE     = 1 << SAT_FRAC_BITS;
	localparam int SAT_CAP     = SAT_ONE - 1;
	localparam int RANDOM_PIX  = 400;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DIRECTED_N  = 18;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [12:0] hue;
		logic [11:0] saturation;
		logic [8:0]  lightness_sum;
	} hsl_t;

	typedef struct packed {
		pixel_t px;
		bit     known;
		hsl_t   hsl;
	} stim_row_t;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;   // red, green, blue
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;   // hue, saturation, lightness_sum

	hsl_t      hsl_due_q[$];
	stim_row_t directed_rows[DIRECTED_N];
	int        pixels_sent;
	int        hsl_seen;
	int        mismatches;
	int        cycles;

	rgb_to_hsl_converter u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic hsl_t hsl_of_pixel(input pixel_t px);
		int      r;
		int      g;
		int      b;
		int      top;
		int      bottom;
		int      span;
		int      sum;
		int      denom;
		int      sat;
		int      hue;
		int      num;
		int      offset;
		sector_t sec;
		hsl_t    res;
		r = px.red;
		g = px.green;
		b = px.blue;
		top = r;
		sec = SEC_RED;
		if (g > top) begin
			top = g;
			sec = SEC_GREEN;
		end
		if (b > top) begin
			top = b;
			sec = SEC_BLUE;
		end
		bottom = r;
		if (g < bottom) bottom = g;
		if (b < bottom) bottom = b;
		span = top - bottom;
		sum = top + bottom;
		if (span == 0) begin
			hue = 0;
			sat = 0;
		end else begin
			denom = (sum <= FULL) ? sum : (2 * FULL - sum);
			sat = (SAT_ONE * span) / denom;
			if (sat > SAT_CAP) sat = SAT_CAP;
			case (sec)
				SEC_RED: begin
					num = g - b;
					offset = 0;
				end
				SEC_GREEN: begin
					num = b - r;
					offset = 2 * HUE_UNIT;
				end
				default: begin
					num = r - g;
					offset = 4 * HUE_UNIT;
				end
			endcase
			hue = (num * HUE_UNIT) / span + offset;
			if (hue < 0) hue += 6 * HUE_UNIT;
		end
		res.hue = 13'(hue);
		res.saturation = 12'(sat);
		res.lightness_sum = 9'(sum);
		return res;
	endfunction

	task automatic offer_pixel(input pixel_t px, input hsl_t want);
		int gap;
		bit taken;
		gap = 0;
		if (!(pixels_sent >= 250 && pixels_sent < 330)) begin
			while ($urandom_range(0, 99) < 36 && gap < 20) gap++;
		end
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {px.blue, px.green, px.red};
		do begin
			@(negedge clk);
			taken = s_tvalid && s_tready;
			@(posedge clk);
		end while (!taken);
		hsl_due_q.push_back(want);
		pixels_sent++;
	endtask

	task automatic check_hsl(input logic [OUT_W-1:0] word);
		hsl_t got;
		hsl_t want;
		got.hue = word[12:0];
		got.saturation = word[24:13];
		got.lightness_sum = word[33:25];
		if (hsl_due_q.size() == 0) begin
			$error("unexpected result: hue %0d, saturation %0d, lightness_sum %0d",
				got.hue, got.saturation, got.lightness_sum);
			mismatches++;
		end else begin
			want = hsl_due_q.pop_front();
			if (got.hue !== want.hue) begin
				$error("hue: expected %0d, got %0d", want.hue, got.hue);
				mismatches++;
			end
			if (got.saturation !== want.saturation) begin
				$error("saturation: expected %0d, got %0d", want.saturation, got.saturation);
				mismatches++;
			end
			if (got.lightness_sum !== want.lightness_sum) begin
				$error("lightness_sum: expected %0d, got %0d",
					want.lightness_sum, got.lightness_sum);
				mismatches++;
			end
		end
	endtask

	// Output side: random back-pressure, one long hold-off, one quiet stretch.
	initial begin
		int stall_left;
		bit held;
		m_tready = 1'b0;
		stall_left = 0;
		held = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (!held && hsl_seen >= 60) begin
				held = 1'b1;
				stall_left = 80;
			end
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (hsl_seen >= 200 && hsl_seen < 300) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= 36);
			end
			@(negedge clk);
			if (m_tvalid && m_tready) begin
				check_hsl(m_tdata);
				hsl_seen++;
			end
			@(posedge clk);
		end
	end

	initial begin
		pixel_t px;
		hsl_t   want;
		int     mode;
		int     v;
		int     pick;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cycles = 0;
		pixels_sent = 0;
		hsl_seen = 0;
		mismatches = 0;

		directed_rows = '{
			'{'{8'd0,   8'd0,   8'd0},   1'b1, '{13'd0,    12'd0,    9'd0}},
			'{'{8'd255, 8'd255, 8'd255}, 1'b1, '{13'd0,    12'd0,    9'd510}},
			'{'{8'd128, 8'd128, 8'd128}, 1'b1, '{13'd0,    12'd0,    9'd256}},
			'{'{8'd255, 8'd0,   8'd0},   1'b1, '{13'd0,    12'd4095, 9'd255}},
			'{'{8'd0,   8'd255, 8'd0},   1'b1, '{13'd2048, 12'd4095, 9'd255}},
			'{'{8'd0,   8'd0,   8'd255}, 1'b1, '{13'd4096, 12'd4095, 9'd255}},
			'{'{8'd255, 8'd255, 8'd0},   1'b1, '{13'd1024, 12'd4095, 9'd255}},
			'{'{8'd0,   8'd255, 8'd255}, 1'b1, '{13'd3072, 12'd4095, 9'd255}},
			'{'{8'd255, 8'd0,   8'd255}, 1'b1, '{13'd5120, 12'd4095, 9'd255}},
			'{'{8'd1,   8'd0,   8'd0},   1'b1, '{13'd0,    12'd4095, 9'd1}},
			'{'{8'd255, 8'd254, 8'd254}, 1'b1, '{13'd0,    12'd4095, 9'd509}},
			'{'{8'd100, 8'd10,  8'd20},  1'b0, '0},
			'{'{8'd200, 8'd100, 8'd50},  1'b0, '0},
			'{'{8'haa,  8'h55,  8'haa},  1'b0, '0},
			'{'{8'h55,  8'haa,  8'haa},  1'b0, '0},
			'{'{8'd128, 8'd127, 8'd127}, 1'b0, '0},
			'{'{8'd128, 8'd129, 8'd127}, 1'b0, '0},
			'{'{8'd10,  8'd250, 8'd5},   1'b0, '0}
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			want = directed_rows[i].known ? directed_rows[i].hsl
				: hsl_of_pixel(directed_rows[i].px);
			offer_pixel(directed_rows[i].px, want);
		end

		// Mostly uniform pixels, with greys, tied maxima and saturated channels.
		for (int n = 0; n < RANDOM_PIX; n++) begin
			mode = $urandom_range(0, 9);
			v = $urandom_range(0, 255);
			px.red = 8'($urandom_range(0, 255));
			px.green = 8'($urandom_range(0, 255));
			px.blue = 8'($urandom_range(0, 255));
			case (mode)
				0: px = '{8'(v), 8'(v), 8'(v)};
				1: begin
					pick = $urandom_range(0, 2);
					px = '{8'($urandom_range(0, v)), 8'($urandom_range(0, v)),
						8'($urandom_range(0, v))};
					if (pick != 2) px.red = 8'(v);
					if (pick != 1) px.green = 8'(v);
					if (pick != 0) px.blue = 8'(v);
				end
				2: begin
					if ($urandom_range(0, 1)) px.red = $urandom_range(0, 1) ? 8'd255 : 8'd0;
					if ($urandom_range(0, 1)) px.green = $urandom_range(0, 1) ? 8'd255 : 8'd0;
					if ($urandom_range(0, 1)) px.blue = $urandom_range(0, 1) ? 8'd255 : 8'd0;
				end
				default: ;
			endcase
			offer_pixel(px, hsl_of_pixel(px));
		end
		s_tvalid <= 1'b0;

		while (hsl_due_q.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
